[sv/assert_macros.svh]
// Assertion macros shared by the timer queue RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define DLTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that forces a consequent in the following cycle.
`define DLTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dlts_pkg.sv]
// Types, constants and codes of the delta-list timer queue.
// Used by every module of the block but the entry RAM; depends on nothing.
package dlts_pkg;

    localparam int MAX_TASKS    = 16;
    localparam int IDX_W        = $clog2(MAX_TASKS);
    localparam int CNT_W        = $clog2(MAX_TASKS + 1);
    localparam int RESULT_LIMIT = 16;
    localparam int NRES_W       = $clog2(RESULT_LIMIT + 1);
    localparam int TIME_W       = 32;
    localparam int HANDLE_W     = 8;
    localparam int SLOT_W       = 4;
    localparam int STEP_W       = 10;
    localparam int STEP_RESET   = 10;
    localparam int S_TDATA_W    = 80;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 3;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP = 1'b0;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_DEL  = 2'd2,
        ACT_DISP = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_NONE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_SUB     = 2'd0,
        ALU_SUB_SAT = 2'd1,
        ALU_ADD_SAT = 2'd2
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_TICK_RD,
        S_INS_START,
        S_WALK,
        S_WALK_FIX,
        S_INS_SHIFT,
        S_INS_MOVE,
        S_INS_WRITE,
        S_DEL_RD,
        S_DEL_SHIFT,
        S_DEL_MOVE,
        S_DEL_END,
        S_DEL_FIX,
        S_DISP_CHK,
        S_DISP_RD,
        S_DISP_EMIT,
        S_DISP_TAKE,
        S_DISP_END,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delta;
        logic [TIME_W-1:0]   period;
        logic                due;
    } entry_t;

    typedef struct packed {
        action_t             action;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic [SLOT_W-1:0]   slot_index;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] due_handle;
        logic                due_valid;
        logic [TIME_W-1:0]   time_now;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0] res;
        logic              borrow;
    } alu_out_t;

endpackage

[sv/delta_list_task_scheduler_unit.sv]
// Delta-list timer queue, top level.
// Commands arrive on the s_ stream: s_tuser selects tick, add, delete or
// dispatch, s_tdata carries handle, delay, period and slot index. Each
// command gives one or more results on the m_ stream; m_tlast marks the
// final result of a command. The APB port holds tick_step at address 0.
// One command is worked on at a time and s_tready is low meanwhile. All work
// goes through one entry RAM that reads and writes one entry per cycle and one
// shared 32-bit add/subtract unit. A tick updates the head entry; an add walks
// the list up to its insertion position and shifts the count - position
// entries behind it; a delete shifts the entries behind the removed one. A
// dispatch releases one due head at a time by a delete and, for a periodic
// task, an add, and ends with a final check and result.
// The RAM needs no clearing after reset: reset empties the list, zeroes the
// timestamp and sets tick_step to 10, and the block is ready at once.
// Results pass through an output register, so a new command is taken while a
// result waits; a stalled receiver holds the sequencer at its next result.
`include "assert_macros.svh"

module delta_list_task_scheduler_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: task_handle[7:0], delay[39:8], period[71:40], slot_index[75:72], zeros
    input  logic [dlts_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: action[1:0]
    input  logic [dlts_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: slot[3:0], due_handle[11:4], time_now[43:12], zeros
    output logic [dlts_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: status[1:0], due_valid[2]
    output logic [dlts_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dlts_pkg::APB_AW-1:0]       paddr,
    input  logic [dlts_pkg::APB_DW-1:0]       pwdata,
    output logic [dlts_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import dlts_pkg::*;

    logic [STEP_W-1:0]    step_reg;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_write;

    item_t                in_item;
    logic                 seq_valid;
    logic                 out_free;
    result_t              seq_result;

    logic                 out_valid_reg;
    result_t              out_reg;

    assign pready    = 1'b1;
    assign cfg_index = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (psel && (cfg_index == REG_TICK_STEP)) ? APB_DW'(step_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_W'(STEP_RESET);
        end
        else if (cfg_write && (cfg_index == REG_TICK_STEP))
        begin
            step_reg <= pwdata[STEP_W-1:0];
        end
    end

    assign in_item.action     = action_t'(s_tuser);
    assign in_item.handle     = s_tdata[7:0];
    assign in_item.delay      = s_tdata[39:8];
    assign in_item.period     = s_tdata[71:40];
    assign in_item.slot_index = s_tdata[75:72];

    dlts_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .step       (step_reg),
        .out_valid  (seq_valid),
        .out_free   (out_free),
        .out_result (seq_result)
    );

    // The output register takes a new result in the same cycle as the old one transfers.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= seq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && seq_valid)
        begin
            out_reg <= seq_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - SLOT_W - HANDLE_W - TIME_W)'(0),
                       out_reg.time_now, out_reg.due_handle, out_reg.slot};
    assign m_tuser  = {out_reg.due_valid, out_reg.status};
    assign m_tlast  = out_reg.last;

    `DLTS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "sequencer took a command while one was in flight")
    `DLTS_ASSERT_NEXT(a_step_written,
        cfg_write && (cfg_index == REG_TICK_STEP),
        step_reg == $past(pwdata[STEP_W-1:0]),
        "tick_step did not take the written value")
    `DLTS_ASSERT(a_none_is_final,
        !(m_tvalid && (m_tuser[1:0] == ST_NONE)) || (m_tlast && !m_tuser[2]),
        "nothing-due result must be the single, final result without a handle")

endmodule

[sv/dlts_entry_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the timer list entries; depends on nothing.
module dlts_entry_ram #(
    parameter  int DEPTH = 16,
    parameter  int WIDTH = 73,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so later states may still use it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/dlts_alu.sv]
// Shared 32-bit add/subtract unit with saturating variants.
// Depends on dlts_pkg for the operation codes and result struct.
module dlts_alu (
    input  dlts_pkg::alu_op_t            op,
    input  logic [dlts_pkg::TIME_W-1:0]  a,
    input  logic [dlts_pkg::TIME_W-1:0]  b,
    output dlts_pkg::alu_out_t           y
);
    import dlts_pkg::*;

    logic              sub;
    logic [TIME_W:0]   sum;

    assign sub = (op != ALU_ADD_SAT);
    assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{TIME_W{1'b0}}, sub};

    // For a subtraction a missing carry out means b was larger than a.
    always_comb
    begin
        y.borrow = sub & ~sum[TIME_W];
        unique case (op)
            ALU_SUB:     y.res = sum[TIME_W-1:0];
            ALU_SUB_SAT: y.res = sum[TIME_W] ? sum[TIME_W-1:0] : '0;
            ALU_ADD_SAT: y.res = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            default:     y.res = sum[TIME_W-1:0];
        endcase
    end

endmodule

[sv/dlts_seq.sv]
// Sequencer of the timer queue: walks, shifts and patches the entry RAM
// through the shared ALU. Depends on dlts_pkg, dlts_entry_ram and dlts_alu.
module dlts_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dlts_pkg::item_t               in_item,
    input  logic [dlts_pkg::STEP_W-1:0]   step,
    output logic                          out_valid,
    input  logic                          out_free,
    output dlts_pkg::result_t             out_result
);
    import dlts_pkg::*;

    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    seq_state_t          state_reg, state_next;
    item_t               item_reg, item_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   tick_time_reg, tick_time_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [TIME_W-1:0]   dsave_reg, dsave_next;
    logic [NRES_W-1:0]   nres_reg, nres_next;
    logic                disp_reg, disp_next;
    result_t             res_reg, res_next;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    entry_t              ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    entry_t              rd_entry;

    alu_op_t             alu_op;
    logic [TIME_W-1:0]   alu_a;
    logic [TIME_W-1:0]   alu_b;
    alu_out_t            alu_y;

    logic [CNT_W:0]      pos_w, ptr_w, cnt_w, pos_p1, ptr_p1, ptr_p2;
    logic [CNT_W-1:0]    ptr_m1, ptr_m2, cnt_m1;
    logic [CMP_W-1:0]    sidx_ext, cnt_ext;
    logic                head_due;
    logic                list_full;
    seq_state_t          del_finish;

    dlts_entry_ram #(
        .DEPTH (MAX_TASKS),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_entry)
    );

    dlts_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign pos_w    = {1'b0, pos_reg};
    assign ptr_w    = {1'b0, ptr_reg};
    assign cnt_w    = {1'b0, count_reg};
    assign pos_p1   = pos_w + (CNT_W+1)'(1);
    assign ptr_p1   = ptr_w + (CNT_W+1)'(1);
    assign ptr_p2   = ptr_w + (CNT_W+1)'(2);
    assign ptr_m1   = ptr_reg - CNT_W'(1);
    assign ptr_m2   = ptr_reg - CNT_W'(2);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign sidx_ext = CMP_W'(item_reg.slot_index);
    assign cnt_ext  = CMP_W'(count_reg);
    assign head_due  = rd_entry.due || (rd_entry.delta == '0);
    assign list_full = (count_reg >= CNT_W'(MAX_TASKS));

    // After removal: response, or in a dispatch the loop, re-adding a periodic task first.
    always_comb
    begin
        if (disp_reg)
        begin
            del_finish = (item_reg.period != '0) ? S_INS_START : S_DISP_CHK;
        end
        else
        begin
            del_finish = S_RESP;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_START;
                end
            S_START:
                unique case (item_reg.action)
                    ACT_TICK: state_next = (count_reg != '0) ? S_TICK_RD : S_RESP;
                    ACT_ADD:  state_next = list_full ? S_RESP : S_INS_START;
                    ACT_DEL:  state_next = (sidx_ext >= cnt_ext) ? S_RESP : S_DEL_RD;
                    ACT_DISP: state_next = S_DISP_CHK;
                endcase
            S_TICK_RD:
                state_next = S_RESP;
            S_INS_START:
                state_next = (count_reg == '0) ? S_INS_WRITE : S_WALK;
            S_WALK:
                if (alu_y.borrow)
                begin
                    state_next = S_WALK_FIX;
                end
                else if (pos_p1 == cnt_w)
                begin
                    state_next = S_INS_SHIFT;
                end
            S_WALK_FIX:
                state_next = S_INS_SHIFT;
            S_INS_SHIFT:
                state_next = (ptr_reg > pos_reg) ? S_INS_MOVE : S_INS_WRITE;
            S_INS_MOVE:
                if (!(ptr_m1 > pos_reg))
                begin
                    state_next = S_INS_WRITE;
                end
            S_INS_WRITE:
                state_next = disp_reg ? S_DISP_CHK : S_RESP;
            S_DEL_RD:
                state_next = S_DEL_SHIFT;
            S_DEL_SHIFT:
                state_next = (ptr_p1 < cnt_w) ? S_DEL_MOVE : S_DEL_END;
            S_DEL_MOVE:
                if (!(ptr_p2 < cnt_w))
                begin
                    state_next = S_DEL_END;
                end
            S_DEL_END:
                state_next = (pos_reg < cnt_m1) ? S_DEL_FIX : del_finish;
            S_DEL_FIX:
                state_next = del_finish;
            S_DISP_CHK:
                if ((count_reg != '0) && (nres_reg < NRES_W'(RESULT_LIMIT)))
                begin
                    state_next = S_DISP_RD;
                end
                else
                begin
                    state_next = S_DISP_END;
                end
            S_DISP_RD:
                if (!head_due)
                begin
                    state_next = S_DISP_END;
                end
                else if (nres_reg == '0)
                begin
                    state_next = S_DISP_TAKE;
                end
                else
                begin
                    state_next = S_DISP_EMIT;
                end
            S_DISP_EMIT:
                if (out_free)
                begin
                    state_next = S_DISP_TAKE;
                end
            S_DISP_TAKE:
                state_next = S_DEL_SHIFT;
            S_DISP_END:
                state_next = S_RESP;
            S_RESP:
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // RAM, ALU and handshake controls.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg[IDX_W-1:0];
        ram_wr_data = rd_entry;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        alu_op      = ALU_SUB;
        alu_a       = rem_reg;
        alu_b       = rd_entry.delta;
        in_ready    = (state_reg == S_IDLE);
        out_valid   = (state_reg == S_RESP) || (state_reg == S_DISP_EMIT);
        out_result  = res_reg;
        out_result.time_now = tick_time_reg;
        unique case (state_reg)
            S_START:
                if ((item_reg.action == ACT_TICK) && (count_reg != '0))
                begin
                    ram_rd_en = 1'b1;
                end
                else if ((item_reg.action == ACT_DEL) && (sidx_ext < cnt_ext))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = IDX_W'(item_reg.slot_index);
                end
            S_TICK_RD:
            begin
                alu_op      = ALU_SUB_SAT;
                alu_a       = rd_entry.delta;
                alu_b       = TIME_W'(step);
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data.delta = alu_y.res;
                ram_wr_data.due   = rd_entry.due || (alu_y.res == '0);
            end
            S_INS_START:
                ram_rd_en = (count_reg != '0);
            S_WALK:
                if (!alu_y.borrow && (pos_p1 != cnt_w))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_p1[IDX_W-1:0];
                end
            S_WALK_FIX:
            begin
                alu_a       = rd_entry.delta;
                alu_b       = rem_reg;
                ram_wr_en   = 1'b1;
                ram_wr_data.delta = alu_y.res;
            end
            S_INS_SHIFT:
                if (ptr_reg > pos_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_m1[IDX_W-1:0];
                end
            S_INS_MOVE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg[IDX_W-1:0];
                if (ptr_m1 > pos_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_m2[IDX_W-1:0];
                end
            end
            S_INS_WRITE:
            begin
                ram_wr_en          = 1'b1;
                ram_wr_data.handle = item_reg.handle;
                ram_wr_data.delta  = rem_reg;
                ram_wr_data.period = item_reg.period;
                ram_wr_data.due    = 1'b0;
            end
            S_DEL_SHIFT:
                if (ptr_p1 < cnt_w)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_p1[IDX_W-1:0];
                end
            S_DEL_MOVE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg[IDX_W-1:0];
                if (ptr_p2 < cnt_w)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_p2[IDX_W-1:0];
                end
            end
            S_DEL_END:
                if (pos_reg < cnt_m1)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_reg[IDX_W-1:0];
                end
            S_DEL_FIX:
            begin
                alu_op      = ALU_ADD_SAT;
                alu_a       = rd_entry.delta;
                alu_b       = dsave_reg;
                ram_wr_en   = 1'b1;
                ram_wr_data.delta = alu_y.res;
            end
            S_DISP_CHK:
                ram_rd_en = (count_reg != '0) && (nres_reg < NRES_W'(RESULT_LIMIT));
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        item_next      = item_reg;
        count_next     = count_reg;
        tick_time_next = tick_time_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        dsave_next     = dsave_reg;
        nres_next      = nres_reg;
        disp_next      = disp_reg;
        res_next       = res_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    item_next = in_item;
                    disp_next = (in_item.action == ACT_DISP);
                    nres_next = '0;
                    if (in_item.action == ACT_TICK)
                    begin
                        tick_time_next = tick_time_reg + TIME_W'(1);
                    end
                    res_next = '{status: ST_OK, slot: '0, due_handle: '0, due_valid: 1'b0,
                                 time_now: '0, last: 1'b1};
                end
            S_START:
                unique case (item_reg.action)
                    ACT_ADD:
                        if (list_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                    ACT_DEL:
                        if (sidx_ext >= cnt_ext)
                        begin
                            res_next.status = ST_BADPOS;
                        end
                        else
                        begin
                            pos_next = CNT_W'(item_reg.slot_index);
                        end
                    default:
                    begin
                    end
                endcase
            S_INS_START:
            begin
                rem_next = item_reg.delay;
                pos_next = '0;
                ptr_next = count_reg;
            end
            S_WALK:
                if (!alu_y.borrow)
                begin
                    rem_next = alu_y.res;
                    pos_next = pos_p1[CNT_W-1:0];
                end
            S_INS_MOVE:
                ptr_next = ptr_m1;
            S_INS_WRITE:
            begin
                count_next = count_reg + CNT_W'(1);
                if (!disp_reg)
                begin
                    res_next.slot = SLOT_W'(pos_reg);
                end
            end
            S_DEL_RD:
            begin
                dsave_next = rd_entry.delta;
                ptr_next   = pos_reg;
            end
            S_DEL_MOVE:
                ptr_next = ptr_p1[CNT_W-1:0];
            S_DEL_END:
                count_next = cnt_m1;
            S_DISP_RD:
                res_next = '{status: ST_OK, slot: '0, due_handle: item_reg.handle,
                             due_valid: 1'b1, time_now: '0, last: 1'b0};
            S_DISP_TAKE:
            begin
                item_next.handle = rd_entry.handle;
                item_next.period = rd_entry.period;
                item_next.delay  = rd_entry.period;
                dsave_next       = rd_entry.delta;
                pos_next         = '0;
                ptr_next         = '0;
                nres_next        = nres_reg + NRES_W'(1);
            end
            S_DISP_END:
                if (nres_reg == '0)
                begin
                    res_next = '{status: ST_NONE, slot: '0, due_handle: '0, due_valid: 1'b0,
                                 time_now: '0, last: 1'b1};
                end
                else
                begin
                    // The last released handle was held back until the loop ended.
                    res_next = '{status: ST_OK, slot: '0, due_handle: item_reg.handle,
                                 due_valid: 1'b1, time_now: '0, last: 1'b1};
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tick_time_reg <= '0;
            nres_reg      <= '0;
            disp_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tick_time_reg <= tick_time_next;
            nres_reg      <= nres_next;
            disp_reg      <= disp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        pos_reg   <= pos_next;
        ptr_reg   <= ptr_next;
        rem_reg   <= rem_next;
        dsave_reg <= dsave_next;
        res_reg   <= res_next;
    end

endmodule

[tb/sv/delta_list_task_scheduler_unit_test.sv]
// Self-checking testbench of the delta-list timer queue: commands go in on the s_ stream,
// a local model of the ordered list predicts every result and the m_ stream is checked.
// Depends on dlts_pkg and delta_list_task_scheduler_unit.
module delta_list_task_scheduler_unit_test;
    import dlts_pkg::*;

    localparam int STALL_LIMIT      = 5000;
    localparam int RANDOM_PER_PHASE = 115;
    localparam int DRAIN_CYCLES     = 100;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata: task_handle[7:0], delay[39:8], period[71:40], slot_index[75:72], zeros
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // s_tuser: action[1:0]
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata: slot[3:0], due_handle[11:4], time_now[43:12], zeros
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: status[1:0], due_valid[2]
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Local copy of the timer list.
    logic [HANDLE_W-1:0]  list_handle [MAX_TASKS];
    logic [TIME_W-1:0]    list_delta  [MAX_TASKS];
    logic [TIME_W-1:0]    list_period [MAX_TASKS];
    logic                 list_due    [MAX_TASKS];
    int unsigned          list_count = 0;
    logic [TIME_W-1:0]    clock_now  = '0;
    logic [STEP_W-1:0]    step_size  = STEP_W'(STEP_RESET);

    item_t   queued_commands[$];
    result_t awaited_results[$];
    item_t   offered_cmd;
    int      send_idle_pct = 25;
    int      recv_idle_pct = 70;
    int      mismatch_count = 0;
    int      stall_cycles = 0;
    logic    timed_out = 1'b0;

    delta_list_task_scheduler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The new task goes after every entry whose running total does not exceed its delay.
    function automatic int insert_entry(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] dly,
                                        logic [TIME_W-1:0] per);
        logic [TIME_W:0]   total;
        logic [TIME_W-1:0] rel;
        int                pos;
        total = '0;
        pos = 0;
        while (pos < list_count && total + list_delta[pos] <= {1'b0, dly})
        begin
            total = total + list_delta[pos];
            pos++;
        end
        rel = dly - total[TIME_W-1:0];
        if (pos < list_count)
            list_delta[pos] = list_delta[pos] - rel;
        for (int i = list_count; i > pos; i--)
        begin
            list_handle[i] = list_handle[i - 1];
            list_delta[i]  = list_delta[i - 1];
            list_period[i] = list_period[i - 1];
            list_due[i]    = list_due[i - 1];
        end
        list_handle[pos] = h;
        list_delta[pos]  = rel;
        list_period[pos] = per;
        list_due[pos]    = 1'b0;
        list_count++;
        return pos;
    endfunction

    // The removed delta moves to the following entry only, saturating at the top.
    function automatic void remove_entry(int pos);
        logic [TIME_W-1:0] rel;
        logic [TIME_W:0]   sum;
        rel = list_delta[pos];
        for (int i = pos; i + 1 < list_count; i++)
        begin
            list_handle[i] = list_handle[i + 1];
            list_delta[i]  = list_delta[i + 1];
            list_period[i] = list_period[i + 1];
            list_due[i]    = list_due[i + 1];
        end
        list_count--;
        if (pos < list_count)
        begin
            sum = {1'b0, list_delta[pos]} + rel;
            list_delta[pos] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
    endfunction

    function automatic void note_result(status_t st, logic [SLOT_W-1:0] sl,
                                        logic [HANDLE_W-1:0] h, logic v);
        result_t r;
        r.status     = st;
        r.slot       = sl;
        r.due_handle = h;
        r.due_valid  = v;
        r.time_now   = clock_now;
        r.last       = 1'b0;
        awaited_results.push_back(r);
    endfunction

    function automatic void forecast_command(item_t c);
        result_t             r;
        int                  n;
        int                  pos;
        logic [HANDLE_W-1:0] h;
        logic [TIME_W-1:0]   p;
        n = 0;
        case (c.action)
            ACT_TICK:
            begin
                clock_now = clock_now + 1;
                if (list_count > 0)
                begin
                    list_delta[0] = (list_delta[0] > step_size) ? list_delta[0] - step_size : '0;
                    if (list_delta[0] == 0)
                        list_due[0] = 1'b1;
                end
                note_result(ST_OK, '0, '0, 1'b0);
            end
            ACT_ADD:
            begin
                if (list_count >= MAX_TASKS)
                    note_result(ST_FULL, '0, '0, 1'b0);
                else
                begin
                    pos = insert_entry(c.handle, c.delay, c.period);
                    note_result(ST_OK, SLOT_W'(pos), '0, 1'b0);
                end
            end
            ACT_DEL:
            begin
                if (c.slot_index >= list_count)
                    note_result(ST_BADPOS, '0, '0, 1'b0);
                else
                begin
                    remove_entry(c.slot_index);
                    note_result(ST_OK, '0, '0, 1'b0);
                end
            end
            default:
            begin
                while (n < RESULT_LIMIT && list_count > 0 && (list_due[0] || list_delta[0] == 0))
                begin
                    h = list_handle[0];
                    p = list_period[0];
                    remove_entry(0);
                    if (p != 0)
                        void'(insert_entry(h, p, p));
                    note_result(ST_OK, '0, h, 1'b1);
                    n++;
                end
                if (n == 0)
                    note_result(ST_NONE, '0, '0, 1'b0);
            end
        endcase
        r = awaited_results.pop_back();
        r.last = 1'b1;
        awaited_results.push_back(r);
    endfunction

    function automatic void compare_result(result_t got);
        result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("result transfer with nothing expected: status %0d, due_handle %0d",
                   got.status, got.due_handle);
            mismatch_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.status != want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.slot != want.slot)
            begin
                $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                mismatch_count++;
            end
            if (got.due_handle != want.due_handle)
            begin
                $error("due_handle: expected %0d, actual %0d", want.due_handle, got.due_handle);
                mismatch_count++;
            end
            if (got.due_valid != want.due_valid)
            begin
                $error("due_valid: expected %0d, actual %0d", want.due_valid, got.due_valid);
                mismatch_count++;
            end
            if (got.time_now != want.time_now)
            begin
                $error("time_now: expected %0d, actual %0d", want.time_now, got.time_now);
                mismatch_count++;
            end
            if (got.last != want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatch_count++;
            end
        end
    endfunction

    function automatic item_t make_cmd(action_t a, logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] d,
                                       logic [TIME_W-1:0] p, logic [SLOT_W-1:0] s);
        item_t c;
        c.action     = a;
        c.handle     = h;
        c.delay      = d;
        c.period     = p;
        c.slot_index = s;
        return c;
    endfunction

    // Mostly short delays so that ticks make tasks due; one item in ten is pure noise.
    function automatic item_t random_command();
        item_t c;
        int    pick;
        c.action     = action_t'(2'($urandom_range(0, 3)));
        c.handle     = HANDLE_W'($urandom());
        c.delay      = $urandom();
        c.period     = $urandom();
        c.slot_index = SLOT_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return c;
        if (pick < 42)
            c.action = ACT_ADD;
        else if (pick < 70)
            c.action = ACT_TICK;
        else if (pick < 87)
            c.action = ACT_DISP;
        else
            c.action = ACT_DEL;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            c.delay = '0;
        else if (pick < 6)
            c.delay = $urandom_range(0, 40);
        else if (pick == 6)
            c.delay = $urandom_range(0, 3000);
        else if (pick == 7)
            c.delay = '1;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            c.period = '0;
        else if (pick < 8)
            c.period = $urandom_range(1, 40);
        else if (pick == 8)
            c.period = '1;
        if ($urandom_range(0, 3) != 0)
            c.slot_index = SLOT_W'($urandom_range(0, 7));
        return c;
    endfunction

    // Command driver: valid is only dropped when the current transfer has completed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                forecast_command(offered_cmd);
            if (!s_tvalid || s_tready)
            begin
                if (queued_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered_cmd = queued_commands.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, offered_cmd.slot_index, offered_cmd.period,
                                 offered_cmd.delay, offered_cmd.handle};
                    s_tuser  <= offered_cmd.action;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = status_t'(m_tuser[1:0]);
            got.due_valid  = m_tuser[2];
            got.slot       = m_tdata[3:0];
            got.due_handle = m_tdata[11:4];
            got.time_now   = m_tdata[43:12];
            got.last       = m_tlast;
            compare_result(got);
        end
    end

    // Counts cycles with work outstanding but no transfer on either stream.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (awaited_results.size() == 0 && !s_tvalid))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
                timed_out <= 1'b1;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic settle();
        while (!timed_out &&
               (queued_commands.size() != 0 || s_tvalid || awaited_results.size() != 0))
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tick_step(logic [STEP_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TICK_STEP, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        step_size = value;
    endtask

    task automatic run_random_phase(logic [STEP_W-1:0] step, int sender_idle, int receiver_idle);
        settle();
        write_tick_step(step);
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        repeat (RANDOM_PER_PHASE)
            queued_commands.push_back(random_command());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty-list cases first, then ties on equal totals, bad positions,
        // a full list and one dispatch that releases a long run of due heads.
        queued_commands.push_back(make_cmd(ACT_DISP, 8'h00, 32'h0, 32'h0, 4'd0));
        queued_commands.push_back(make_cmd(ACT_DEL, 8'h11, 32'h0, 32'h0, 4'd0));
        queued_commands.push_back(make_cmd(ACT_TICK, 8'h22, 32'h0, 32'h0, 4'd0));
        queued_commands.push_back(make_cmd(ACT_ADD, 8'hFF, 32'h0, 32'h0, 4'd0));
        queued_commands.push_back(make_cmd(ACT_ADD, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
        queued_commands.push_back(make_cmd(ACT_ADD, 8'hA5, 32'd25, 32'd30, 4'd0));
        queued_commands.push_back(make_cmd(ACT_ADD, 8'h5A, 32'd25, 32'd0, 4'd0));
        queued_commands.push_back(make_cmd(ACT_DEL, 8'h00, 32'h0, 32'h0, 4'hF));
        queued_commands.push_back(make_cmd(ACT_DEL, 8'h00, 32'h0, 32'h0, 4'd1));
        for (int i = 0; i < 13; i++)
            queued_commands.push_back(make_cmd(ACT_ADD, HANDLE_W'(8'h30 + i), 32'h0, 32'd3, 4'd0));
        queued_commands.push_back(make_cmd(ACT_ADD, 8'h77, 32'd1, 32'd0, 4'd0));
        queued_commands.push_back(make_cmd(ACT_TICK, 8'h00, 32'h0, 32'h0, 4'd0));
        queued_commands.push_back(make_cmd(ACT_DISP, 8'h00, 32'h0, 32'h0, 4'd0));

        run_random_phase(STEP_W'(1), 25, 70);
        run_random_phase(STEP_W'(1000), 70, 25);
        run_random_phase(STEP_W'($urandom_range(1, 1000)), 0, 0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0 && !timed_out)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
